// File: rtl/assert_macros.svh
// Assertion macros shared by the de-skew RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LBMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LBMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lbmd_pkg.sv
// Package for the lidar beam de-skew block: payload types, codes and constants.
// Used by every module of the block; depends on nothing.
package lbmd_pkg;

  localparam int MAX_SEG_BEAMS = 1024;
  localparam int CORDIC_STEPS  = 16;

  localparam int SEGW = $clog2(MAX_SEG_BEAMS + 1);
  localparam int KW   = $clog2(MAX_SEG_BEAMS);
  localparam int NUMW = 33 + KW;
  localparam int ITW  = $clog2(CORDIC_STEPS);

  // CORDIC datapath width, split point and accumulator of the gain removal.
  localparam int W    = 40;
  localparam int UL   = 20;
  localparam int ACCW = 65;
  localparam int ATAN_IW = 5;

  localparam logic [23:0] INVK = 24'd10188014;

  localparam logic [31:0] ATAN_TAB [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_SEGMENT = 2'd1;
  localparam logic [1:0] CMD_BEAM    = 2'd2;

  localparam logic [1:0] REG_BASE_X   = 2'd0;
  localparam logic [1:0] REG_BASE_Y   = 2'd1;
  localparam logic [1:0] REG_BASE_YAW = 2'd2;

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_YAW = 2'd2;

  localparam logic [1:0] PASS_BEAM   = 2'd0;
  localparam logic [1:0] PASS_OFFSET = 2'd1;
  localparam logic [1:0] PASS_VECTOR = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [23:0]  pose_x;
    logic signed [23:0]  pose_y;
    logic signed [15:0]  pose_yaw;
    logic [10:0]         seg_count;
    logic [15:0]         beam_range;
    logic signed [15:0]  beam_angle;
  } in_item_t;

  typedef struct packed {
    logic [15:0]         out_range;
    logic signed [15:0]  out_angle;
    logic                seg_last;
    logic                range_clipped;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_SEGMENT, OP_CAPTURE, OP_NUM, OP_ACC,
    OP_LOAD, OP_ITER, OP_UNSC, OP_RESULT
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NUM, ST_DIV, ST_ACC, ST_LOAD, ST_ITER, ST_UNSC, ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t      op;
    logic [1:0]  axis;
    logic [1:0]  pass;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic iter_last;
    logic unsc_done;
  } dp_sts_t;

endpackage

// File: rtl/lbmd_div.sv
// Restoring divider, one quotient bit per cycle, for the pose interpolation.
// Depends on lbmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbmd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lbmd_pkg::NUMW-1:0]  num,
  input  logic [lbmd_pkg::KW-1:0]    den,
  output logic [lbmd_pkg::NUMW-1:0]  quot,
  output logic                       done
);

  localparam int CW = $clog2(lbmd_pkg::NUMW + 1);

  logic [lbmd_pkg::NUMW-1:0] rq_r;
  logic [lbmd_pkg::KW-1:0]   rem_r;
  logic [lbmd_pkg::KW-1:0]   den_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [lbmd_pkg::KW:0]     trial;
  logic                      ge;

  assign trial = {rem_r, rq_r[lbmd_pkg::NUMW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(lbmd_pkg::NUMW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rq_r  <= {rq_r[lbmd_pkg::NUMW-2:0], ge};
      rem_r <= ge ? lbmd_pkg::KW'(trial - {1'b0, den_r}) : trial[lbmd_pkg::KW-1:0];
    end
  end

  assign quot = rq_r;
  assign done = done_r;

  `LBMD_ASSERT(a_div_no_restart, busy_r |-> !start, "divider restarted while busy")

endmodule

// File: rtl/lbmd_ctrl.sv
// Sequencer of the de-skew block: handshakes and the order of datapath steps.
// Depends on lbmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbmd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lbmd_pkg::dp_cmd_t cmd,
  input  lbmd_pkg::dp_sts_t sts
);

  lbmd_pkg::state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_out;
  logic       st_out, st_div, st_num, beam_take;

  assign load_out = (state_r == lbmd_pkg::ST_OUT) && (!out_valid_r || out_ready);

  // Short names for the state decodes that the checks below refer to.
  assign st_out    = (state_r == lbmd_pkg::ST_OUT);
  assign st_div    = (state_r == lbmd_pkg::ST_DIV);
  assign st_num    = (state_r == lbmd_pkg::ST_NUM);
  assign beam_take = (state_r == lbmd_pkg::ST_IDLE) && in_valid &&
                     (in_cmd == lbmd_pkg::CMD_BEAM);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    pass_nxt  = pass_r;
    case (state_r)
      lbmd_pkg::ST_IDLE: begin
        if (in_valid && in_cmd == lbmd_pkg::CMD_BEAM) begin
          state_nxt = lbmd_pkg::ST_NUM;
          axis_nxt  = lbmd_pkg::AXIS_X;
        end
      end
      lbmd_pkg::ST_NUM: state_nxt = lbmd_pkg::ST_DIV;
      lbmd_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = lbmd_pkg::ST_ACC;
      end
      lbmd_pkg::ST_ACC: begin
        if (axis_r == lbmd_pkg::AXIS_YAW) begin
          state_nxt = lbmd_pkg::ST_LOAD;
          pass_nxt  = lbmd_pkg::PASS_BEAM;
        end else begin
          state_nxt = lbmd_pkg::ST_NUM;
          axis_nxt  = axis_r + 2'd1;
        end
      end
      lbmd_pkg::ST_LOAD: state_nxt = lbmd_pkg::ST_ITER;
      lbmd_pkg::ST_ITER: begin
        if (sts.iter_last) state_nxt = lbmd_pkg::ST_UNSC;
      end
      lbmd_pkg::ST_UNSC: begin
        if (sts.unsc_done) begin
          if (pass_r == lbmd_pkg::PASS_VECTOR) begin
            state_nxt = lbmd_pkg::ST_OUT;
          end else begin
            state_nxt = lbmd_pkg::ST_LOAD;
            pass_nxt  = pass_r + 2'd1;
          end
        end
      end
      lbmd_pkg::ST_OUT: begin
        if (load_out) state_nxt = lbmd_pkg::ST_IDLE;
      end
      default: state_nxt = lbmd_pkg::ST_IDLE;
    endcase
    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_comb begin
    in_ready = (state_r == lbmd_pkg::ST_IDLE);
    cmd.op   = lbmd_pkg::OP_NONE;
    cmd.axis = axis_r;
    cmd.pass = pass_r;
    case (state_r)
      lbmd_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            lbmd_pkg::CMD_START:   cmd.op = lbmd_pkg::OP_START;
            lbmd_pkg::CMD_SEGMENT: cmd.op = lbmd_pkg::OP_SEGMENT;
            lbmd_pkg::CMD_BEAM:    cmd.op = lbmd_pkg::OP_CAPTURE;
            default:               cmd.op = lbmd_pkg::OP_NONE;
          endcase
        end
      end
      lbmd_pkg::ST_NUM:  cmd.op = lbmd_pkg::OP_NUM;
      lbmd_pkg::ST_ACC:  cmd.op = lbmd_pkg::OP_ACC;
      lbmd_pkg::ST_LOAD: cmd.op = lbmd_pkg::OP_LOAD;
      lbmd_pkg::ST_ITER: cmd.op = lbmd_pkg::OP_ITER;
      lbmd_pkg::ST_UNSC: cmd.op = lbmd_pkg::OP_UNSC;
      lbmd_pkg::ST_OUT: begin
        if (load_out) cmd.op = lbmd_pkg::OP_RESULT;
      end
      default: cmd.op = lbmd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbmd_pkg::ST_IDLE;
      axis_r      <= lbmd_pkg::AXIS_X;
      pass_r      <= lbmd_pkg::PASS_BEAM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LBMD_ASSERT(a_out_from_out_state, $rose(out_valid_r) |-> $past(st_out), "stray result beat")
  `LBMD_ASSERT(a_div_done_in_div, sts.div_done |-> st_div, "quotient done outside divide step")
  `LBMD_ASSERT_NEXT(a_beam_starts, beam_take, st_num, "beam did not start interpolation")

endmodule

// File: rtl/lbmd_dp.sv
// Datapath of the de-skew block: poses, interpolation, shared CORDIC, gain removal.
// Depends on lbmd_pkg and lbmd_div.
module lbmd_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lbmd_pkg::dp_cmd_t   cmd,
  output lbmd_pkg::dp_sts_t   sts,
  input  lbmd_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  output lbmd_pkg::out_item_t out_data
);

  localparam int W    = lbmd_pkg::W;
  localparam int KW   = lbmd_pkg::KW;
  localparam int SEGW = lbmd_pkg::SEGW;
  localparam int NUMW = lbmd_pkg::NUMW;
  localparam int ITW  = lbmd_pkg::ITW;
  localparam int ACCW = lbmd_pkg::ACCW;
  localparam int UL   = lbmd_pkg::UL;
  localparam int PW   = 34;
  localparam int PRW  = 24 + KW;
  localparam logic signed [31:0] QTR  = 32'sh4000_0000;
  localparam logic signed [31:0] NQTR = 32'shC000_0000;

  logic signed [23:0] base_x_r, base_y_r, sx_r, sy_r, ex_r, ey_r;
  logic signed [15:0] base_yaw_r, syaw_r, eyaw_r;
  logic [SEGW-1:0]    seg_r;
  logic [KW-1:0]      k_r;
  logic [ITW-1:0]     it_r;
  logic [1:0]         un_r;

  logic [15:0]           rng_r;
  logic signed [15:0]    bang_r;
  logic                  neg_r;
  logic signed [PW-1:0]  mx_r, my_r;
  logic [31:0]           myaw_r;
  logic signed [W-1:0]   cx_r, cy_r, bx_r, by_r, ox_r, oy_r, mag_r;
  logic [31:0]           cz_r;
  logic                  vec_r, zero_r;
  logic signed [ACCW-1:0] acc_r;
  lbmd_pkg::out_item_t   out_data_r;

  // Interpolation numerator
  logic [KW-1:0]         den;
  logic signed [15:0]    dyaw;
  logic signed [24:0]    dlt;
  logic [23:0]           dmag;
  logic [PRW-1:0]        prod;
  logic [NUMW-1:0]       num;
  logic [NUMW-1:0]       quot;
  logic                  div_done;
  logic signed [32:0]    qs;

  assign den  = KW'(seg_r - SEGW'(1));
  assign dyaw = eyaw_r - syaw_r;

  always_comb begin
    case (cmd.axis)
      lbmd_pkg::AXIS_X: dlt = 25'(ex_r) - 25'(sx_r);
      lbmd_pkg::AXIS_Y: dlt = 25'(ey_r) - 25'(sy_r);
      default:          dlt = 25'(dyaw);
    endcase
  end

  assign dmag = dlt[24] ? 24'(-dlt) : dlt[23:0];
  assign prod = PRW'(dmag) * PRW'(k_r);

  always_comb begin
    if (cmd.axis == lbmd_pkg::AXIS_YAW) begin
      num = (NUMW'(prod) << 16) + NUMW'(den >> 1);
    end else begin
      num = (NUMW'(prod) << 8) + NUMW'(den >> 1);
    end
  end

  lbmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == lbmd_pkg::OP_NUM),
    .num   (num),
    .den   (den),
    .quot  (quot),
    .done  (div_done)
  );

  assign qs = neg_r ? -$signed({1'b0, quot[31:0]}) : $signed({1'b0, quot[31:0]});

  // CORDIC pass set-up
  logic [31:0]         theta, zb, rz;
  logic signed [W-1:0] rx, ry, vx, vy;
  logic                fold;

  assign theta = myaw_r + {bang_r, 16'h0} - {base_yaw_r, 16'h0};
  assign zb    = 32'h0 - {base_yaw_r, 16'h0};
  assign vx    = bx_r + ox_r;
  assign vy    = by_r + oy_r;

  always_comb begin
    if (cmd.pass == lbmd_pkg::PASS_BEAM) begin
      rx = W'({rng_r, 8'h0});
      ry = '0;
      rz = theta;
    end else begin
      rx = W'(mx_r) - (W'(base_x_r) <<< 8);
      ry = W'(my_r) - (W'(base_y_r) <<< 8);
      rz = zb;
    end
  end

  assign fold = ($signed(rz) > QTR) || ($signed(rz) < NQTR);

  // CORDIC step
  logic signed [W-1:0] xs, ys;
  logic [31:0]         at;
  logic                dir;

  assign xs  = cx_r >>> it_r;
  assign ys  = cy_r >>> it_r;
  assign at  = lbmd_pkg::ATAN_TAB[lbmd_pkg::ATAN_IW'(it_r)];
  assign dir = vec_r ? cy_r[W-1] : ~cz_r[31];

  // Gain removal, two partial products per component
  logic signed [W-1:0]     uv;
  logic [UL-1:0]           vl;
  logic signed [W-UL-1:0]  vh;
  logic [UL+23:0]          lo_prod;
  logic signed [W-UL+24:0] hi_prod;
  logic signed [ACCW-1:0]  usum;
  logic signed [W-1:0]     ures;

  assign uv      = un_r[1] ? cy_r : cx_r;
  assign vl      = uv[UL-1:0];
  assign vh      = uv[W-1:UL];
  assign lo_prod = (UL+24)'(vl) * (UL+24)'(lbmd_pkg::INVK);
  assign hi_prod = (W-UL+25)'(vh) * $signed((W-UL+25)'(lbmd_pkg::INVK));
  assign usum    = acc_r + ($signed(ACCW'(hi_prod)) <<< UL);
  assign ures    = usum[W+23:24];

  // Output formatting
  logic signed [W-1:0] r_full;
  logic [31:0]         ang_full;
  logic                last;

  assign r_full   = (mag_r + W'(128)) >>> 8;
  assign ang_full = cz_r + 32'd32768;
  assign last     = (k_r == den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r   <= '0;
      base_y_r   <= '0;
      base_yaw_r <= '0;
      sx_r       <= '0;
      sy_r       <= '0;
      syaw_r     <= '0;
      ex_r       <= '0;
      ey_r       <= '0;
      eyaw_r     <= '0;
      seg_r      <= SEGW'(2);
      k_r        <= '0;
      it_r       <= '0;
      un_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          lbmd_pkg::REG_BASE_X:   base_x_r   <= cfg_data;
          lbmd_pkg::REG_BASE_Y:   base_y_r   <= cfg_data;
          lbmd_pkg::REG_BASE_YAW: base_yaw_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (cmd.op)
        lbmd_pkg::OP_START: begin
          sx_r   <= base_x_r;
          sy_r   <= base_y_r;
          syaw_r <= base_yaw_r;
          ex_r   <= base_x_r;
          ey_r   <= base_y_r;
          eyaw_r <= base_yaw_r;
          k_r    <= '0;
        end
        lbmd_pkg::OP_SEGMENT: begin
          sx_r   <= ex_r;
          sy_r   <= ey_r;
          syaw_r <= eyaw_r;
          ex_r   <= in_data.pose_x;
          ey_r   <= in_data.pose_y;
          eyaw_r <= in_data.pose_yaw;
          k_r    <= '0;
          if (32'(in_data.seg_count) < 32'd2) begin
            seg_r <= SEGW'(2);
          end else if (32'(in_data.seg_count) > 32'(lbmd_pkg::MAX_SEG_BEAMS)) begin
            seg_r <= SEGW'(lbmd_pkg::MAX_SEG_BEAMS);
          end else begin
            seg_r <= SEGW'(in_data.seg_count);
          end
        end
        lbmd_pkg::OP_LOAD: begin
          it_r <= '0;
          un_r <= '0;
        end
        lbmd_pkg::OP_ITER: it_r <= it_r + ITW'(1);
        lbmd_pkg::OP_UNSC: un_r <= un_r + 2'd1;
        lbmd_pkg::OP_RESULT: begin
          if (!last) k_r <= k_r + KW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lbmd_pkg::OP_CAPTURE: begin
        rng_r  <= in_data.beam_range;
        bang_r <= in_data.beam_angle;
      end
      lbmd_pkg::OP_NUM: neg_r <= dlt[24];
      lbmd_pkg::OP_ACC: begin
        case (cmd.axis)
          lbmd_pkg::AXIS_X: mx_r   <= (PW'(sx_r) <<< 8) + PW'(qs);
          lbmd_pkg::AXIS_Y: my_r   <= (PW'(sy_r) <<< 8) + PW'(qs);
          default:          myaw_r <= {syaw_r, 16'h0} + qs[31:0];
        endcase
      end
      lbmd_pkg::OP_LOAD: begin
        if (cmd.pass == lbmd_pkg::PASS_VECTOR) begin
          vec_r  <= 1'b1;
          zero_r <= (vx == '0) && (vy == '0);
          if (vx < 0) begin
            cx_r <= -vx;
            cy_r <= -vy;
            cz_r <= 32'h8000_0000;
          end else begin
            cx_r <= vx;
            cy_r <= vy;
            cz_r <= '0;
          end
        end else begin
          vec_r <= 1'b0;
          if (fold) begin
            cx_r <= -rx;
            cy_r <= -ry;
            cz_r <= {~rz[31], rz[30:0]};
          end else begin
            cx_r <= rx;
            cy_r <= ry;
            cz_r <= rz;
          end
        end
      end
      lbmd_pkg::OP_ITER: begin
        if (dir) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      lbmd_pkg::OP_UNSC: begin
        if (!un_r[0]) begin
          acc_r <= $signed(ACCW'(lo_prod)) + $signed(ACCW'(64'h80_0000));
        end else begin
          case (cmd.pass)
            lbmd_pkg::PASS_BEAM: begin
              if (un_r[1]) by_r <= ures;
              else         bx_r <= ures;
            end
            lbmd_pkg::PASS_OFFSET: begin
              if (un_r[1]) oy_r <= ures;
              else         ox_r <= ures;
            end
            default: begin
              if (!un_r[1]) mag_r <= ures;
            end
          endcase
        end
      end
      lbmd_pkg::OP_RESULT: begin
        out_data_r.seg_last  <= last;
        out_data_r.out_angle <= zero_r ? 16'sh0 : $signed(ang_full[31:16]);
        if (r_full < 0) begin
          out_data_r.out_range     <= 16'h0;
          out_data_r.range_clipped <= 1'b0;
        end else if (r_full > W'(65535)) begin
          out_data_r.out_range     <= 16'hFFFF;
          out_data_r.range_clipped <= 1'b1;
        end else begin
          out_data_r.out_range     <= r_full[15:0];
          out_data_r.range_clipped <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign sts.div_done  = div_done;
  assign sts.iter_last = (it_r == ITW'(lbmd_pkg::CORDIC_STEPS - 1));
  assign sts.unsc_done = (un_r == 2'd3);
  assign out_data      = out_data_r;

endmodule

// File: rtl/lidar_beam_motion_deskew.sv
// Top level of the planar lidar beam de-skew block.
// Depends on lbmd_pkg, lbmd_ctrl and lbmd_dp.
//
// Usage. Items arrive on the in_ channel (valid/ready); one beat carries one
// command. A start beat copies the base pose (cfg registers 0..2) into both
// segment poses. A segment beat shifts the old end pose to the start and
// loads a new end pose and beam count. Neither gives a result. A beam beat
// yields exactly one result beat on the out_ channel: the beam re-expressed
// in the base frame as range (saturated, with a clip flag) and bearing.
// Order of work: a beat is taken only while the block is idle, so one beam is
// processed at a time. Three serial divisions of 43 steps each (one quotient
// bit a cycle) produce the interpolated pose, then one shared CORDIC runs
// three passes of 16 iterations, each followed by the gain removal. Start and
// segment beats are handled while idle. The next beat is accepted while a
// finished result waits in the output register; a new result is only
// written once that register is free, so a stalled receiver holds the block.
// Reset (synchronous, rst_n low) zeroes the base and segment poses, sets the
// beam count to two and the beam index to zero, and empties the output.
// Configuration writes take effect at once and belong to idle periods.
module lidar_beam_motion_deskew (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lbmd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lbmd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_data
);

  // Commands from the sequencer and status back from the datapath.
  lbmd_pkg::dp_cmd_t dp_cmd;
  lbmd_pkg::dp_sts_t dp_sts;

  lbmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  lbmd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench for lidar_beam_motion_deskew: drives start, segment and beam beats,
// predicts each corrected beam with a bit-true fixed-point model and compares results.
// Depends on lbmd_pkg and the RTL of the block.
module tb;

  // Codes outside the defined sets, used to check that they are ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  lbmd_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lbmd_pkg::out_item_t out_data;
  logic      cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;

  lidar_beam_motion_deskew DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Predictor state: base pose registers and the current segment.
  longint pbase_x, pbase_y, pbase_yaw;
  longint seg_sx, seg_sy, seg_syaw, seg_ex, seg_ey, seg_eyaw;
  longint seg_beams, seg_idx;

  lbmd_pkg::out_item_t beam_results_q[$];
  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time. The slowest correct run is around 1200 beats, most of
  // them beams, plus sender gaps and receiver stalls; this gives ample margin.
  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

  function automatic longint sx(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v[w-1]) return v - (longint'(1) << w);
    return v;
  endfunction

  // Floor shift; >>> on a signed longint is already arithmetic.
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // Rounded division, half away from zero, positive divisor.
  function automatic longint rnd_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint atan_step(int i);
    return longint'(lbmd_pkg::ATAN_TAB[i]);
  endfunction

  function automatic longint gain_fix(longint v);
    return fshr(v * 10188014 + (longint'(1) << 23), 24);
  endfunction

  // Rotate vector (x, y) by binary angle z, with quadrant fold beyond +-pi/2.
  task automatic cordic_rotate(inout longint x, inout longint y, input longint z);
    longint xs, ys;
    if (z > (longint'(1) << 30)) begin
      x = -x; y = -y; z = z - (longint'(1) << 31);
    end else if (z < -(longint'(1) << 30)) begin
      x = -x; y = -y; z = z + (longint'(1) << 31);
    end
    for (int i = 0; i < lbmd_pkg::CORDIC_STEPS; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end
    end
    x = gain_fix(x);
    y = gain_fix(y);
  endtask

  task automatic cordic_polar(input longint x, input longint y, output longint mag,
                              output longint ang);
    longint xs, ys, z;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = longint'(1) << 31;
    end
    for (int i = 0; i < lbmd_pkg::CORDIC_STEPS; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end
    end
    mag = gain_fix(x);
    ang = z;
  endtask

  function automatic void apply_reg(logic [1:0] idx, logic [23:0] val);
    if (idx == lbmd_pkg::REG_BASE_X) pbase_x = sx(longint'(val), 24);
    else if (idx == lbmd_pkg::REG_BASE_Y) pbase_y = sx(longint'(val), 24);
    else if (idx == lbmd_pkg::REG_BASE_YAW) pbase_yaw = sx(longint'(val), 16);
  endfunction

  // Advance the segment state for one accepted beat; returns 1 with the corrected beam.
  task automatic deskew_beat(input lbmd_pkg::in_item_t it, output bit has_res,
                             output lbmd_pkg::out_item_t res);
    longint den, k, c, mx, my, dyaw, myaw, theta, bx, by, ox, oy, mag, ang, r;
    bit last, clip;
    has_res = 0;
    res = '0;
    if (it.cmd == lbmd_pkg::CMD_START) begin
      seg_sx = pbase_x; seg_sy = pbase_y; seg_syaw = pbase_yaw;
      seg_ex = pbase_x; seg_ey = pbase_y; seg_eyaw = pbase_yaw;
      seg_idx = 0;
    end else if (it.cmd == lbmd_pkg::CMD_SEGMENT) begin
      c = longint'(it.seg_count);
      if (c < 2) c = 2;
      if (c > lbmd_pkg::MAX_SEG_BEAMS) c = lbmd_pkg::MAX_SEG_BEAMS;
      seg_sx = seg_ex; seg_sy = seg_ey; seg_syaw = seg_eyaw;
      seg_ex = longint'(it.pose_x);
      seg_ey = longint'(it.pose_y);
      seg_eyaw = longint'(it.pose_yaw);
      seg_beams = c;
      seg_idx = 0;
    end else if (it.cmd == lbmd_pkg::CMD_BEAM) begin
      den = seg_beams - 1;
      if (den < 1) den = 1;
      k = seg_idx;
      if (k > den) k = den;
      mx = seg_sx * 256 + rnd_div((seg_ex - seg_sx) * 256 * k, den);
      my = seg_sy * 256 + rnd_div((seg_ey - seg_sy) * 256 * k, den);
      dyaw = sx(seg_eyaw - seg_syaw, 16);
      myaw = seg_syaw * 65536 + rnd_div(dyaw * 65536 * k, den);
      theta = sx(myaw + longint'(it.beam_angle) * 65536 - pbase_yaw * 65536, 32);
      bx = longint'(it.beam_range) * 256;
      by = 0;
      cordic_rotate(bx, by, theta);
      ox = mx - pbase_x * 256;
      oy = my - pbase_y * 256;
      cordic_rotate(ox, oy, sx(-pbase_yaw * 65536, 32));
      cordic_polar(bx + ox, by + oy, mag, ang);
      r = fshr(mag + 128, 8);
      clip = 0;
      if (r < 0) r = 0;
      if (r > 65535) begin
        r = 65535; clip = 1;
      end
      last = (k == den);
      if (!last) k++;
      seg_idx = k;
      res.out_range = r[15:0];
      res.out_angle = 16'(fshr(ang + 32768, 16));
      res.seg_last = last;
      res.range_clipped = clip;
      has_res = 1;
    end
  endtask

  // Receiver: stalls at random at the current pressure and checks each result beat.
  always @(posedge clk) begin
    lbmd_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (beam_results_q.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = beam_results_q.pop_front();
        if (out_data.out_range !== want.out_range) begin
          $error("out_range expected %0d got %0d", want.out_range, out_data.out_range);
          errors++;
        end
        if (out_data.out_angle !== want.out_angle) begin
          $error("out_angle expected %0d got %0d", want.out_angle, out_data.out_angle);
          errors++;
        end
        if (out_data.seg_last !== want.seg_last) begin
          $error("seg_last expected %0d got %0d", want.seg_last, out_data.seg_last);
          errors++;
        end
        if (out_data.range_clipped !== want.range_clipped) begin
          $error("range_clipped expected %0d got %0d", want.range_clipped,
                 out_data.range_clipped);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One beat on the input channel. The payload is set up at a falling edge, the
  // acceptance is seen at the rising edge, and the prediction is made there too so
  // that the expectation is queued before its result can possibly return. Valid
  // stays high after acceptance, so that the next beat follows back to back; it
  // is dropped only when the sender idles or waits.
  task automatic send_beat(input lbmd_pkg::in_item_t it, input bit typed,
                           input lbmd_pkg::out_item_t typed_res);
    bit has_res;
    lbmd_pkg::out_item_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    deskew_beat(it, has_res, res);
    if (has_res) begin
      if (typed && res !== typed_res) begin
        $error("predictor disagrees with typed row: expected %p got %p", typed_res, res);
        errors++;
      end
      beam_results_q.insert(beam_results_q.size(), res);
    end
    @(negedge clk);
  endtask

  // One register write; the enable drops for a cycle before the next write.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every expected beam has come back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (beam_results_q.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  function automatic lbmd_pkg::in_item_t mk(logic [1:0] c, longint px, longint py,
                                            longint pyaw, longint cnt, longint rng,
                                            longint ang);
    lbmd_pkg::in_item_t it;
    it.cmd = c;
    it.pose_x = 24'(px);
    it.pose_y = 24'(py);
    it.pose_yaw = 16'(pyaw);
    it.seg_count = 11'(cnt);
    it.beam_range = 16'(rng);
    it.beam_angle = 16'(ang);
    return it;
  endfunction

  function automatic lbmd_pkg::out_item_t res_of(longint rng, longint ang, bit last,
                                                 bit clip);
    lbmd_pkg::out_item_t o;
    o.out_range = 16'(rng);
    o.out_angle = 16'(ang);
    o.seg_last = last;
    o.range_clipped = clip;
    return o;
  endfunction

  function automatic lbmd_pkg::in_item_t rand_beat(int mode);
    lbmd_pkg::in_item_t it;
    it = lbmd_pkg::in_item_t'($bits(lbmd_pkg::in_item_t)'({$urandom, $urandom, $urandom,
                                                           $urandom}));
    if (mode == 0) begin
      it.cmd = lbmd_pkg::CMD_BEAM;
    end else if (mode == 1) begin
      it.cmd = lbmd_pkg::CMD_SEGMENT;
      // Mostly short segments so that their ends are reached often.
      if ($urandom_range(9) < 8) it.seg_count = 11'($urandom_range(2, 12));
      if ($urandom_range(3) == 0) begin
        it.pose_x = $signed(it.pose_x) >>> $urandom_range(16);
        it.pose_y = $signed(it.pose_y) >>> $urandom_range(16);
      end
    end else begin
      it.cmd = 2'($urandom_range(3));
    end
    return it;
  endfunction

  typedef struct {
    lbmd_pkg::in_item_t  beat;
    bit                  typed;
    lbmd_pkg::out_item_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(lbmd_pkg::in_item_t b, bit typed,
                                  lbmd_pkg::out_item_t r);
    stim_row_t row;
    row.beat = b;
    row.typed = typed;
    row.res = r;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    int sent;
    int mode;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = lbmd_pkg::REG_BASE_X;
    cfg_data = '0;
    pbase_x = 0; pbase_y = 0; pbase_yaw = 0;
    seg_sx = 0; seg_sy = 0; seg_syaw = 0;
    seg_ex = 0; seg_ey = 0; seg_eyaw = 0;
    seg_beams = 2; seg_idx = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Right after reset everything sits at the origin, so a beam
    // comes back with its own range and angle; a zero-range beam at the origin
    // is the zero vector case, and full-scale beams probe the clip limit.
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0, 0));
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 1, 0));
    // An extra beam beyond the segment end keeps seg_last set.
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 1, 0));
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 1000, 0), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 65535, -32768), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 65535, 32767), 0, '0);
    // The unused command is ignored entirely.
    add_row(mk(CMD_UNUSED, -1, -1, -1, 2047, 65535, -1), 0, '0);
    // Segment counts below two and above the maximum are clamped.
    add_row(mk(lbmd_pkg::CMD_SEGMENT, 8388607, -8388608, 32767, 0, 0, 0), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 65535, 16384), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 65535, -16384), 0, '0);
    add_row(mk(lbmd_pkg::CMD_SEGMENT, -8388608, 8388607, -32768, 2047, 0, 0), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 1, 1), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 65535, 0), 0, '0);
    add_row(mk(lbmd_pkg::CMD_SEGMENT, 1000, 2000, 100, 1, 0, 0), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 5000, 8192), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 5000, -8192), 0, '0);
    // A start beat returns both poses to the base pose.
    add_row(mk(lbmd_pkg::CMD_START, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 1234, 4321), 0, '0);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);
    drain();

    // Extreme base pose. A zero-range beam straight after a start beat sits at the
    // base origin and gives the zero vector; a segment to the opposite corner follows.
    write_reg(lbmd_pkg::REG_BASE_X, 24'h7FFFFF);
    write_reg(lbmd_pkg::REG_BASE_Y, 24'h800000);
    write_reg(lbmd_pkg::REG_BASE_YAW, 24'h008000);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    send_beat(mk(lbmd_pkg::CMD_START, 0, 0, 0, 0, 0, 0), 0, '0);
    send_beat(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0, 0));
    send_beat(mk(lbmd_pkg::CMD_SEGMENT, -8388608, 8388607, 32767, 3, 0, 0), 0, '0);
    for (int i = 0; i < 4; i++)
      send_beat(mk(lbmd_pkg::CMD_BEAM, 0, 0, 0, 0, 65535, i * 9000), 0, '0);
    drain();

    // Random phases: sender idling and receiver stall pressure, then base pose settings between phases.
    phase_idle  = '{0, 86, 0, 36};
    phase_stall = '{0, 0, 86, 36};
    sent = 0;
    for (int p = 0; p < 8; p++) begin
      send_idle_pct  = phase_idle[p % 4];
      recv_stall_pct = phase_stall[p % 4];
      case (p % 4)
        0: begin
          write_reg(lbmd_pkg::REG_BASE_X, 24'h000000);
          write_reg(lbmd_pkg::REG_BASE_Y, 24'h000000);
          write_reg(lbmd_pkg::REG_BASE_YAW, 24'h000000);
        end
        1: begin
          write_reg(lbmd_pkg::REG_BASE_X, 24'h800000);
          write_reg(lbmd_pkg::REG_BASE_Y, 24'h7FFFFF);
          write_reg(lbmd_pkg::REG_BASE_YAW, 24'h007FFF);
        end
        default: begin
          write_reg(lbmd_pkg::REG_BASE_X, 24'($urandom));
          write_reg(lbmd_pkg::REG_BASE_Y, 24'($urandom));
          write_reg(lbmd_pkg::REG_BASE_YAW, 24'($urandom));
        end
      endcase
      send_beat(mk(lbmd_pkg::CMD_START, 0, 0, 0, 0, 0, 0), 0, '0);
      for (int n = 0; n < 150; n++) begin
        mode = $urandom_range(99);
        if (mode < 75) send_beat(rand_beat(0), 0, '0);
        else if (mode < 92) send_beat(rand_beat(1), 0, '0);
        else send_beat(rand_beat(2), 0, '0);
        // Once per phase the sender holds off until the block has emptied.
        if (n == 70) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (beam_results_q.size() != 0);
        end
        sent++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lbmd_pkg.sv
rtl/lbmd_div.sv
rtl/lbmd_ctrl.sv
rtl/lbmd_dp.sv
rtl/lidar_beam_motion_deskew.sv
dv/tb.sv
